@@ rtl/core/ittp_pkg.sv @@
package ittp_pkg;

  // input operation codes
  localparam logic [2:0] OP_OPERAND = 3'd0;
  localparam logic [2:0] OP_FUNC    = 3'd1;
  localparam logic [2:0] OP_OPEN    = 3'd2;
  localparam logic [2:0] OP_CLOSE   = 3'd3;
  localparam logic [2:0] OP_OPER    = 3'd4;
  localparam logic [2:0] OP_END     = 3'd5;

  // operator symbols
  localparam logic [4:0] SYM_ASSIGN = 5'd0;
  localparam logic [4:0] SYM_PLUS   = 5'd1;
  localparam logic [4:0] SYM_MINUS  = 5'd2;
  localparam logic [4:0] SYM_MUL    = 5'd3;
  localparam logic [4:0] SYM_DIV    = 5'd4;
  localparam logic [4:0] SYM_CARET  = 5'd5;
  localparam logic [4:0] SYM_UNARY  = 5'd6;

  // stack entry kinds
  localparam logic [1:0] EK_FUNC = 2'd0;
  localparam logic [1:0] EK_OPEN = 2'd1;
  localparam logic [1:0] EK_OPER = 2'd2;

  // result kinds
  localparam logic [2:0] RK_OPERAND   = 3'd0;
  localparam logic [2:0] RK_FUNC      = 3'd1;
  localparam logic [2:0] RK_OPER      = 3'd2;
  localparam logic [2:0] RK_UNMATCHED = 3'd3;
  localparam logic [2:0] RK_MISMATCH  = 3'd4;
  localparam logic [2:0] RK_OVERFLOW  = 3'd5;

  // commands from the front to the back
  localparam logic [2:0] CMD_OPERAND = 3'd0;
  localparam logic [2:0] CMD_PUSH    = 3'd1;
  localparam logic [2:0] CMD_CLOSE   = 3'd2;
  localparam logic [2:0] CMD_OPER    = 3'd3;
  localparam logic [2:0] CMD_END     = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [2:0] PREC_FUNC = 3'd6;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] sym;
  } entry_t;

  typedef struct packed {
    logic [2:0]  cmd;
    entry_t      entry;
    logic [2:0]  prec;
    logic        right;
    logic [15:0] ref_val;
  } q_item_t;

  function automatic logic [2:0] oper_prec(input logic [4:0] sym);
    logic [2:0] p;
    unique case (sym)
      SYM_ASSIGN:          p = 3'd1;
      SYM_PLUS, SYM_MINUS: p = 3'd2;
      SYM_MUL, SYM_DIV:    p = 3'd3;
      SYM_CARET:           p = 3'd4;
      SYM_UNARY:           p = 3'd5;
      default:             p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] entry_prec(input entry_t e);
    logic [2:0] p;
    p = 3'd0;
    if (e.kind == EK_FUNC) begin
      p = PREC_FUNC;
    end else if (e.kind == EK_OPER) begin
      p = oper_prec(e.sym);
    end
    return p;
  endfunction

  // result kind of an entry popped in the ordinary way
  function automatic logic [2:0] entry_result(input entry_t e);
    logic [2:0] k;
    unique case (e.kind)
      EK_FUNC: k = RK_FUNC;
      EK_OPER: k = RK_OPER;
      default: k = RK_UNMATCHED;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/infix_to_postfix_converter.sv @@
// infix to postfix converter (shunting yard)
// input channel: in_valid/in_ready carry one classified infix token per word
// (operation, symbol, operand_ref). output channel: out_valid/out_ready carry
// postfix words (out_kind, out_symbol, out_operand_ref, last); last marks the
// final word caused by one input token. tokens that cause no word (unknown
// operation or operator, plain pushes) produce nothing on the output.
// a front stage classifies tokens into a two-entry queue, so tokens keep
// being accepted while the back stage works or the receiver stalls.
// the back stage keeps the operator stack in a ram with the top entry held
// in a register; a stack pop with entries left below it is followed by a
// load state (ram read of the next entry), and every token ends in a done
// state that closes the item. each output word is held until the next
// word or the end of its token shows whether it is the last one.
// when out_ready is low, the back stage stops at its next word and the queue
// fills, then in_ready drops. reset (rst, synchronous) empties the stack,
// queue and output register; no clearing pass is needed.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [4:0]  symbol,
  input  logic [15:0] operand_ref,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_symbol,
  output logic [15:0] out_operand_ref,
  output logic        last
);
  import ittp_pkg::*;

  logic    q_push, q_full, q_pop, q_valid;
  q_item_t q_in, q_head;

  ittp_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .symbol      (symbol),
    .operand_ref (operand_ref),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  ittp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  ittp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_symbol      (out_symbol),
    .out_operand_ref (out_operand_ref),
    .last            (last)
  );

endmodule

@@ rtl/core/ittp_ram.sv @@
module ittp_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ittp_front.sv @@
module ittp_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        operation,
  input  logic [4:0]        symbol,
  input  logic [15:0]       operand_ref,
  input  logic              q_full,
  output logic              q_push,
  output ittp_pkg::q_item_t q_item
);
  import ittp_pkg::*;

  logic keep;

  always_comb begin
    q_item         = '0;
    q_item.ref_val = operand_ref;
    keep           = 1'b1;
    unique case (operation)
      OP_OPERAND: begin
        q_item.cmd = CMD_OPERAND;
      end
      OP_FUNC: begin
        q_item.cmd        = CMD_PUSH;
        q_item.entry.kind = EK_FUNC;
        q_item.entry.sym  = symbol;
      end
      OP_OPEN: begin
        q_item.cmd        = CMD_PUSH;
        q_item.entry.kind = EK_OPEN;
        q_item.entry.sym  = {4'b0000, |symbol};
      end
      OP_CLOSE: begin
        q_item.cmd        = CMD_CLOSE;
        q_item.entry.kind = EK_OPEN;
        q_item.entry.sym  = {4'b0000, |symbol};
      end
      OP_OPER: begin
        q_item.cmd        = CMD_OPER;
        q_item.entry.kind = EK_OPER;
        q_item.entry.sym  = symbol;
        q_item.prec       = oper_prec(symbol);
        q_item.right      = (symbol == SYM_CARET) || (symbol == SYM_UNARY);
        // unknown operator symbols give nothing
        keep              = (symbol <= SYM_UNARY);
      end
      OP_END: begin
        q_item.cmd = CMD_END;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

endmodule

@@ rtl/core/ittp_queue.sv @@
module ittp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ittp_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ittp_pkg::q_item_t head_item
);
  import ittp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  q_item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;

  assign full       = (fill == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/ittp_back.sv @@
module ittp_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ittp_pkg::q_item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [4:0]        out_symbol,
  output logic [15:0]       out_operand_ref,
  output logic              last
);
  import ittp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_OPERAND  = 4'd1;
  localparam logic [3:0] S_PUSH     = 4'd2;
  localparam logic [3:0] S_CLOSE    = 4'd3;
  localparam logic [3:0] S_CLOSE_FN = 4'd4;
  localparam logic [3:0] S_OPER     = 4'd5;
  localparam logic [3:0] S_END      = 4'd6;
  localparam logic [3:0] S_LOAD     = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  function automatic logic [3:0] dispatch(input logic [2:0] cmd);
    logic [3:0] s;
    unique case (cmd)
      CMD_OPERAND: s = S_OPERAND;
      CMD_PUSH:    s = S_PUSH;
      CMD_CLOSE:   s = S_CLOSE;
      CMD_OPER:    s = S_OPER;
      CMD_END:     s = S_END;
      default:     s = S_DONE;
    endcase
    return s;
  endfunction

  logic [3:0]   state, state_next;
  logic [3:0]   ret, ret_next;
  q_item_t      cur, cur_next;
  logic [CW-1:0] count, count_next;
  entry_t       tos, tos_next;

  logic         pend_valid, pend_valid_next;
  logic [2:0]   pend_kind;
  logic [4:0]   pend_sym;
  logic [15:0]  pend_ref;

  logic [EW-1:0] rdata;
  logic          full_stack, can_gen, out_free, binds;
  logic          gen, pop, push, try_push, out_load, out_last, flush;
  logic [2:0]    gen_kind;
  logic [4:0]    gen_sym;
  logic [15:0]   gen_ref;
  logic [3:0]    after;
  logic [CW-1:0] below;

  assign full_stack = (count == CW'(STACK_DEPTH));
  assign out_free   = !out_valid || out_ready;
  // a new result goes into the hold slot, pushing the held one out
  assign can_gen    = !pend_valid || out_free;
  assign binds      = (entry_prec(tos) > cur.prec)
                    || ((entry_prec(tos) == cur.prec) && !cur.right);
  assign below      = count - CW'(2);

  ittp_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (count[AW-1:0]),
    .wdata (cur.entry),
    .raddr (below[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cur_next   = cur;
    count_next = count;
    tos_next   = tos;
    gen        = 1'b0;
    gen_kind   = RK_OPERAND;
    gen_sym    = '0;
    gen_ref    = '0;
    pop        = 1'b0;
    push       = 1'b0;
    try_push   = 1'b0;
    after      = state;
    q_pop      = 1'b0;
    flush      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_next   = q_item;
          state_next = dispatch(q_item.cmd);
        end
      end
      S_OPERAND: begin
        if (can_gen) begin
          gen        = 1'b1;
          gen_kind   = RK_OPERAND;
          gen_ref    = cur.ref_val;
          state_next = S_DONE;
        end
      end
      S_PUSH: begin
        try_push = 1'b1;
      end
      S_CLOSE: begin
        if (count == '0) begin
          state_next = S_DONE;
        end else if (tos.kind == EK_OPEN && tos.sym == cur.entry.sym) begin
          pop   = 1'b1;
          after = S_CLOSE_FN;
        end else if (can_gen) begin
          gen      = 1'b1;
          gen_kind = (tos.kind == EK_OPEN) ? RK_MISMATCH : entry_result(tos);
          gen_sym  = tos.sym;
          pop      = 1'b1;
          after    = S_CLOSE;
        end
      end
      S_CLOSE_FN: begin
        if (count != '0 && tos.kind == EK_FUNC) begin
          if (can_gen) begin
            gen      = 1'b1;
            gen_kind = RK_FUNC;
            gen_sym  = tos.sym;
            pop      = 1'b1;
            after    = S_DONE;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_OPER: begin
        if (count != '0 && tos.kind != EK_OPEN && binds) begin
          if (can_gen) begin
            gen      = 1'b1;
            gen_kind = entry_result(tos);
            gen_sym  = tos.sym;
            pop      = 1'b1;
            after    = S_OPER;
          end
        end else begin
          try_push = 1'b1;
        end
      end
      S_END: begin
        if (count == '0) begin
          state_next = S_DONE;
        end else if (can_gen) begin
          gen      = 1'b1;
          gen_kind = entry_result(tos);
          gen_sym  = tos.sym;
          pop      = 1'b1;
          after    = S_END;
        end
      end
      S_LOAD: begin
        tos_next   = rdata;
        state_next = ret;
      end
      S_DONE: begin
        if (!pend_valid || out_free) begin
          flush = pend_valid;
          if (q_valid) begin
            q_pop      = 1'b1;
            cur_next   = q_item;
            state_next = dispatch(q_item.cmd);
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (try_push) begin
      if (full_stack) begin
        if (can_gen) begin
          gen        = 1'b1;
          gen_kind   = RK_OVERFLOW;
          gen_sym    = cur.entry.sym;
          state_next = S_DONE;
        end
      end else begin
        push       = 1'b1;
        tos_next   = cur.entry;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
    end

    if (pop) begin
      count_next = count - CW'(1);
      // the entry below the top is read from the ram and taken over in S_LOAD
      if (count >= CW'(2)) begin
        state_next = S_LOAD;
        ret_next   = after;
      end else begin
        state_next = after;
      end
    end
  end

  assign out_load        = (gen && pend_valid) || flush;
  assign out_last        = flush;
  assign pend_valid_next = gen ? 1'b1 : (flush ? 1'b0 : pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret <= ret_next;
    cur <= cur_next;
    tos <= tos_next;
    if (gen) begin
      pend_kind <= gen_kind;
      pend_sym  <= gen_sym;
      pend_ref  <= gen_ref;
    end
    if (out_load) begin
      out_kind        <= pend_kind;
      out_symbol      <= pend_sym;
      out_operand_ref <= pend_ref;
      last            <= out_last;
    end
  end

endmodule

@@ tb/postfix_checker.sv @@
`timescale 1ns / 1ps

module postfix_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [4:0]  symbol,
  input  logic [15:0] operand_ref,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [4:0]  out_symbol,
  input  logic [15:0] out_operand_ref,
  input  logic        last,
  output int          errors,
  output int          pending,
  output int          words_checked
);
  import ittp_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  sym;
    logic [15:0] ref_val;
    logic        last;
  } word_t;

  entry_t op_entries [STACK_DEPTH];
  int     depth_used;
  word_t  postfix_due [$];
  word_t  item_words [$];
  int     error_total;
  int     checked_total;

  function automatic entry_t make_entry(logic [1:0] kind, logic [4:0] sym);
    entry_t e;
    e.kind = kind;
    e.sym  = sym;
    return e;
  endfunction

  // binding strength of a stack entry; an operator never pops an opener
  function automatic int bind_strength(entry_t e);
    if (e.kind == EK_FUNC) return 6;
    if (e.kind != EK_OPER) return 0;
    case (e.sym)
      SYM_ASSIGN:          return 1;
      SYM_PLUS, SYM_MINUS: return 2;
      SYM_MUL, SYM_DIV:    return 3;
      SYM_CARET:           return 4;
      SYM_UNARY:           return 5;
      default:             return 0;
    endcase
  endfunction

  function automatic void add_word(logic [2:0] kind, logic [4:0] sym, logic [15:0] ref_val);
    word_t w;
    w.kind    = kind;
    w.sym     = sym;
    w.ref_val = ref_val;
    w.last    = 1'b0;
    item_words.push_back(w);
  endfunction

  function automatic void emit_popped(entry_t e);
    case (e.kind)
      EK_FUNC: add_word(RK_FUNC, e.sym, 16'd0);
      EK_OPER: add_word(RK_OPER, e.sym, 16'd0);
      default: add_word(RK_UNMATCHED, e.sym, 16'd0);
    endcase
  endfunction

  function automatic void push_entry(entry_t e);
    if (depth_used >= STACK_DEPTH) begin
      add_word(RK_OVERFLOW, e.sym, 16'd0);
    end else begin
      op_entries[depth_used] = e;
      depth_used++;
    end
  endfunction

  task automatic convert_token(input logic [2:0] op, input logic [4:0] sym,
                               input logic [15:0] ref_val);
    entry_t     e;
    logic [4:0] bracket;
    int         strength;
    bit         found;
    bit         done;
    bit         right_assoc;
    word_t      w;
    item_words.delete();
    bracket = (sym != 5'd0) ? 5'd1 : 5'd0;
    case (op)
      OP_OPERAND: add_word(RK_OPERAND, 5'd0, ref_val);
      OP_FUNC:    push_entry(make_entry(EK_FUNC, sym));
      OP_OPEN:    push_entry(make_entry(EK_OPEN, bracket));
      OP_CLOSE: begin
        found = 1'b0;
        while (depth_used > 0 && !found) begin
          e = op_entries[depth_used - 1];
          depth_used--;
          if (e.kind == EK_OPEN) begin
            // an opener of the other kind is dropped with an error word
            if (e.sym == bracket) found = 1'b1;
            else add_word(RK_MISMATCH, e.sym, 16'd0);
          end else begin
            emit_popped(e);
          end
        end
        if (found && depth_used > 0 && op_entries[depth_used - 1].kind == EK_FUNC) begin
          emit_popped(op_entries[depth_used - 1]);
          depth_used--;
        end
      end
      OP_OPER: begin
        if (sym <= SYM_UNARY) begin
          strength    = bind_strength(make_entry(EK_OPER, sym));
          right_assoc = (sym == SYM_CARET) || (sym == SYM_UNARY);
          done        = 1'b0;
          while (depth_used > 0 && !done) begin
            e = op_entries[depth_used - 1];
            if (e.kind != EK_OPEN && (bind_strength(e) > strength ||
                (bind_strength(e) == strength && !right_assoc))) begin
              emit_popped(e);
              depth_used--;
            end else begin
              done = 1'b1;
            end
          end
          push_entry(make_entry(EK_OPER, sym));
        end
      end
      OP_END: begin
        while (depth_used > 0) begin
          emit_popped(op_entries[depth_used - 1]);
          depth_used--;
        end
      end
      default: ;
    endcase
    if (item_words.size() > 0) begin
      w = item_words.pop_back();
      w.last = 1'b1;
      item_words.push_back(w);
    end
    foreach (item_words[i]) postfix_due.push_back(item_words[i]);
  endtask

  task automatic report(input string msg);
    error_total++;
    $display("%0t postfix_checker: %s", $time, msg);
  endtask

  task automatic check_word;
    word_t w;
    if (postfix_due.size() == 0) begin
      report($sformatf("unexpected word kind %0d symbol %0d ref %h last %b",
                       out_kind, out_symbol, out_operand_ref, last));
    end else begin
      w = postfix_due.pop_front();
      checked_total++;
      if (out_kind !== w.kind)
        report($sformatf("word %0d: kind %0d, want %0d", checked_total, out_kind, w.kind));
      if (out_symbol !== w.sym)
        report($sformatf("word %0d: symbol %0d, want %0d", checked_total, out_symbol, w.sym));
      if (out_operand_ref !== w.ref_val)
        report($sformatf("word %0d: ref %h, want %h", checked_total, out_operand_ref,
                         w.ref_val));
      if (last !== w.last)
        report($sformatf("word %0d: last %b, want %b", checked_total, last, w.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      depth_used = 0;
      postfix_due.delete();
    end else begin
      if (in_valid && in_ready) convert_token(operation, symbol, operand_ref);
      if (out_valid && out_ready) check_word();
    end
    errors        <= error_total;
    pending       <= postfix_due.size();
    words_checked <= checked_total;
  end

endmodule

@@ tb/infix_to_postfix_converter_tb.sv @@
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import ittp_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int RANDOM_TOKENS = 500;
  // operation codes the block must ignore
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;
  localparam logic [4:0] SYM_BAD   = 5'd31;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  sym;
    logic [15:0] ref_val;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = 3'd0;
  logic [4:0]  symbol = 5'd0;
  logic [15:0] operand_ref = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [4:0]  out_symbol;
  logic [15:0] out_operand_ref;
  logic        last;

  int errors;
  int pending;
  int words_checked;

  bit          calm = 1'b0;
  int unsigned ready_hold = 0;
  token_t      plan [$];
  int          tokens_sent = 0;
  int          tokens_effective = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .symbol(symbol),
    .operand_ref(operand_ref),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_symbol(out_symbol),
    .out_operand_ref(out_operand_ref),
    .last(last)
  );

  postfix_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .symbol(symbol),
    .operand_ref(operand_ref),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_symbol(out_symbol),
    .out_operand_ref(out_operand_ref),
    .last(last),
    .errors(errors),
    .pending(pending),
    .words_checked(words_checked)
  );

  always #5 clk = ~clk;

  initial begin
    #(30_000_000);
    $display("tb: failure");
    $finish;
  end

  // receiver: ready runs and stalls of random length, held high when calm
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic token_t tok(logic [2:0] op, logic [4:0] sym, logic [15:0] ref_val);
    token_t t;
    t.op      = op;
    t.sym     = sym;
    t.ref_val = ref_val;
    return t;
  endfunction

  // round is 0, any nonzero code means square
  function automatic logic [4:0] pick_bracket();
    if ($urandom_range(0, 2) == 0) return 5'd0;
    return 5'($urandom_range(1, 31));
  endfunction

  function automatic void add_term(int level);
    int         pick;
    logic [4:0] b;
    pick = (level >= 4) ? 0 : $urandom_range(0, 9);
    if (pick < 4) begin
      plan.push_back(tok(OP_OPERAND, 5'($urandom_range(0, 31)), 16'($urandom)));
    end else if (pick < 6) begin
      plan.push_back(tok(OP_OPER, SYM_UNARY, 16'($urandom)));
      add_term(level + 1);
    end else if (pick < 8) begin
      b = pick_bracket();
      plan.push_back(tok(OP_OPEN, b, 16'($urandom)));
      add_expr(level + 1);
      plan.push_back(tok(OP_CLOSE, (b == 5'd0) ? 5'd0 : pick_bracket() | 5'd1,
                         16'($urandom)));
    end else begin
      plan.push_back(tok(OP_FUNC, 5'($urandom_range(0, 20)), 16'($urandom)));
      plan.push_back(tok(OP_OPEN, 5'd0, 16'($urandom)));
      add_expr(level + 1);
      plan.push_back(tok(OP_CLOSE, 5'd0, 16'($urandom)));
    end
  endfunction

  function automatic void add_expr(int level);
    add_term(level);
    repeat ($urandom_range(0, (level > 1) ? 1 : 3)) begin
      plan.push_back(tok(OP_OPER, 5'($urandom_range(SYM_ASSIGN, SYM_CARET)), 16'($urandom)));
      add_term(level);
    end
  endfunction

  // deep nesting, mostly pushes, to run the stack full
  function automatic void add_nest(int count, bit pushes_only);
    int pick;
    repeat (count) begin
      pick = pushes_only ? $urandom_range(0, 1) : $urandom_range(0, 9);
      case (pick)
        0, 2, 3, 4: plan.push_back(tok(OP_OPEN, pick_bracket(), 16'($urandom)));
        1, 5, 6:    plan.push_back(tok(OP_FUNC, 5'($urandom_range(0, 20)), 16'($urandom)));
        7, 8:       plan.push_back(tok(OP_OPER, 5'($urandom_range(SYM_ASSIGN, SYM_UNARY)),
                                       16'($urandom)));
        default:    plan.push_back(tok(OP_OPERAND, 5'($urandom_range(0, 31)), 16'($urandom)));
      endcase
    end
    if ($urandom_range(0, 1) == 0) plan.push_back(tok(OP_CLOSE, pick_bracket(), 16'($urandom)));
    plan.push_back(tok(OP_END, 5'($urandom_range(0, 31)), 16'($urandom)));
  endfunction

  function automatic void build_sentence();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      add_nest($urandom_range(28, 40), 1'b0);
    end else if (pick < 14) begin
      repeat ($urandom_range(1, 6))
        plan.push_back(tok(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                           16'($urandom)));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        plan.push_back(tok(OP_OPERAND, 5'($urandom_range(0, 31)), 16'($urandom)));
        plan.push_back(tok(OP_OPER, SYM_ASSIGN, 16'($urandom)));
      end
      add_expr(0);
      // broken sentence: drop a token, stray close, or noise
      if ($urandom_range(0, 4) == 0) begin
        idx = $urandom_range(0, plan.size() - 1);
        case ($urandom_range(0, 2))
          0: plan.delete(idx);
          1: plan.insert(idx, tok(OP_CLOSE, pick_bracket(), 16'($urandom)));
          default: plan.insert(idx, tok(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                                        16'($urandom)));
        endcase
      end
      if ($urandom_range(0, 7) != 0)
        plan.push_back(tok(OP_END, 5'($urandom_range(0, 31)), 16'($urandom)));
    end
  endfunction

  task automatic send_token(input token_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= t.op;
    symbol      <= t.sym;
    operand_ref <= t.ref_val;
    do @(posedge clk); while (!in_ready);
    tokens_sent++;
    if (t.op <= OP_END && !(t.op == OP_OPER && t.sym > SYM_UNARY)) tokens_effective++;
  endtask

  task automatic play_plan;
    foreach (plan[i]) send_token(plan[i]);
    plan.delete();
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int random_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan.push_back(tok(OP_OPERAND, 5'd0, 16'h0000));
    plan.push_back(tok(OP_FUNC, 5'd20, 16'h0000));
    plan.push_back(tok(OP_OPEN, 5'd0, 16'hffff));
    plan.push_back(tok(OP_OPERAND, 5'd31, 16'hffff));
    plan.push_back(tok(OP_OPER, SYM_PLUS, 16'h0000));
    plan.push_back(tok(OP_OPER, SYM_UNARY, 16'h0000));
    plan.push_back(tok(OP_OPER, SYM_UNARY, 16'h0000));
    plan.push_back(tok(OP_OPERAND, 5'd0, 16'h1234));
    plan.push_back(tok(OP_OPER, SYM_CARET, 16'h0000));
    plan.push_back(tok(OP_OPERAND, 5'd0, 16'h5678));
    plan.push_back(tok(OP_OPER, SYM_CARET, 16'h0000));
    plan.push_back(tok(OP_OPERAND, 5'd0, 16'h9abc));
    plan.push_back(tok(OP_OPER, SYM_MUL, 16'h0000));
    plan.push_back(tok(OP_OPER, SYM_BAD, 16'h0000));
    plan.push_back(tok(OP_BAD_LO, 5'd3, 16'h0000));
    plan.push_back(tok(OP_BAD_HI, SYM_BAD, 16'hffff));
    plan.push_back(tok(OP_CLOSE, 5'd0, 16'h0000));
    plan.push_back(tok(OP_OPER, SYM_ASSIGN, 16'h0000));
    plan.push_back(tok(OP_OPEN, 5'd9, 16'h0000));
    plan.push_back(tok(OP_OPEN, 5'd0, 16'h0000));
    plan.push_back(tok(OP_OPER, SYM_MINUS, 16'h0000));
    plan.push_back(tok(OP_OPER, SYM_DIV, 16'h0000));
    plan.push_back(tok(OP_CLOSE, 5'd1, 16'h0000));
    plan.push_back(tok(OP_CLOSE, 5'd0, 16'h0000));
    plan.push_back(tok(OP_OPEN, 5'd1, 16'h0000));
    plan.push_back(tok(OP_FUNC, 5'd0, 16'h0000));
    plan.push_back(tok(OP_END, 5'd0, 16'h0000));
    plan.push_back(tok(OP_END, 5'd0, 16'h0000));
    play_plan();
    wait_drained();

    // fill the stack past its depth once for sure
    random_start = tokens_effective;
    add_nest(STACK_DEPTH + 4, 1'b1);
    play_plan();

    while (tokens_effective - random_start < RANDOM_TOKENS) begin
      calm <= ($urandom_range(0, 9) < 3);
      build_sentence();
      play_plan();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
    repeat (100) @(posedge clk);

    $display("tb: %0d tokens sent (%0d not ignored), %0d postfix words checked",
             tokens_sent, tokens_effective, words_checked);
    $display("tb: corner tokens, nested and broken expressions, stack overflow, noise");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
